[rtl/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types, codes and channel helpers of the pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

  // Significant bits of each color channel (4 to 8).
  localparam int unsigned RED_BITS   = 8;
  localparam int unsigned GREEN_BITS = 8;
  localparam int unsigned BLUE_BITS  = 8;

  localparam int unsigned NUM_CHAN = 3;

  localparam logic [7:0]  FULL_OPACITY = 8'd255;
  // Reciprocal of 255 as a 2^-23 fraction.
  localparam logic [15:0] DIV255_MUL   = 16'h8081;

  localparam logic [7:0] ROUND_OFFSET_RST      = 8'd128;
  localparam logic [7:0] TRANSPARENT_LIMIT_RST = 8'd2;
  localparam logic [7:0] OPAQUE_LIMIT_RST      = 8'd253;

  typedef enum logic [1:0] {
    ACT_NORMAL = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_SUB    = 2'd2,
    ACT_MUL    = 2'd3
  } pbu_action_e;

  typedef enum logic [1:0] {
    REG_ROUND_OFFSET      = 2'd0,
    REG_TRANSPARENT_LIMIT = 2'd1,
    REG_OPAQUE_LIMIT      = 2'd2
  } pbu_reg_e;

  // Per-pixel result source.
  typedef enum logic [1:0] {
    SEL_DST,
    SEL_FG,
    SEL_MIX
  } pbu_sel_e;

  typedef logic [NUM_CHAN-1:0][7:0] pbu_pix_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] opacity;
  } pbu_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pbu_out_t;

  // Stage 1 payload: foreground color, destination, opacity and select.
  typedef struct packed {
    pbu_sel_e   sel;
    pbu_pix_t   fg;
    pbu_pix_t   dst;
    logic [7:0] opa;
  } pbu_s1_t;

  // Load enables of the two arithmetic stages.
  typedef struct packed {
    logic ld2;
    logic ld3;
  } pbu_adv_t;

  function automatic logic [3:0] chan_bits(input logic [1:0] c);
    logic [3:0] b;
    case (c)
      2'd0:    b = 4'(RED_BITS);
      2'd1:    b = 4'(GREEN_BITS);
      default: b = 4'(BLUE_BITS);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] chan_mask(input logic [1:0] c);
    logic [8:0] m;
    m = (9'd1 << chan_bits(c)) - 9'd1;
    return m[7:0];
  endfunction

endpackage

[rtl/pbu_mix.sv]
// ----------------------------------------------------------------------------
// pbu_mix
// Mixing stages: weighted sum with rounding, then divide by 255 and select.
// ----------------------------------------------------------------------------
module pbu_mix (
  input  logic             clk_i,
  input  pbu_pkg::pbu_adv_t adv_i,
  input  logic [7:0]       round_offset_i,
  input  pbu_pkg::pbu_s1_t s1_i,
  output pbu_pkg::pbu_out_t out_o
);
  import pbu_pkg::*;

  logic [NUM_CHAN-1:0][15:0] sum_d, sum_q;
  pbu_pix_t                  fg_q, dst_q;
  pbu_sel_e                  sel_q;
  pbu_pix_t                  res_d, res_q;

  // Stage 2: fg*opa + dst*(255-opa) + rounding offset.
  always_comb begin
    logic [7:0]  inv;
    logic [16:0] acc;
    inv = FULL_OPACITY - s1_i.opa;
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = 17'(16'(s1_i.fg[c] * s1_i.opa)) + 17'(16'(s1_i.dst[c] * inv))
          + 17'(round_offset_i);
      sum_d[c] = acc[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld2) begin
      sum_q <= sum_d;
      fg_q  <= s1_i.fg;
      dst_q <= s1_i.dst;
      sel_q <= s1_i.sel;
    end
  end

  // Stage 3: divide by 255 as (x * 0x8081) >> 23, then pick the source.
  always_comb begin
    logic [31:0] prod;
    logic [7:0]  mixed;
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod  = 32'(sum_q[c]) * 32'(DIV255_MUL);
      mixed = prod[30:23] & chan_mask(2'(c));
      case (sel_q)
        SEL_FG:  res_d[c] = fg_q[c];
        SEL_MIX: res_d[c] = mixed;
        default: res_d[c] = dst_q[c];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld3) begin
      res_q <= res_d;
    end
  end

  assign out_o.out_red   = res_q[0];
  assign out_o.out_green = res_q[1];
  assign out_o.out_blue  = res_q[2];

endmodule

[rtl/pixel_blend_unit.sv]
// ----------------------------------------------------------------------------
// pixel_blend_unit
// Per-pixel blender: normal, additive, subtractive and multiply modes.
// ----------------------------------------------------------------------------
// The unit takes one pixel request per clock unless the output stalls and
// returns blended pixels in order, one result per request. The three
// register stages are: channel combine and mode decision, the weighted sum
// of foreground and destination with rounding, and the divide by 255 with
// final selection into the output register. Throughput is one pixel per
// clock; out_ready_i low stalls the pipe without loss, and bubbles in the
// pipe are filled while a result waits. Configuration writes are always
// accepted (cfg_ready_o is tied high) and must only arrive while the unit
// is idle; writes to index 3 are dropped.
module pixel_blend_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  // Pixel requests
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbu_pkg::pbu_in_t  in_data_i,
  // Blended pixels
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbu_pkg::pbu_out_t out_data_o
);
  import pbu_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] round_offset_q, transparent_limit_q, opaque_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_offset_q      <= ROUND_OFFSET_RST;
      transparent_limit_q <= TRANSPARENT_LIMIT_RST;
      opaque_limit_q      <= OPAQUE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROUND_OFFSET:      round_offset_q      <= cfg_data_i;
        REG_TRANSPARENT_LIMIT: transparent_limit_q <= cfg_data_i;
        REG_OPAQUE_LIMIT:      opaque_limit_q      <= cfg_data_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when the one after it is empty or
  // is moving on in the same cycle.
  // --------------------------------------------------------------------------
  logic     v1_q, v2_q, v3_q;
  logic     take1, take2, take3;
  pbu_adv_t adv;

  assign take3 = !v3_q || out_ready_i;
  assign take2 = !v2_q || take3;
  assign take1 = !v1_q || take2;

  assign in_ready_o  = take1;
  assign out_valid_o = v3_q;

  assign adv.ld2 = take2 && v1_q;
  assign adv.ld3 = take3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (take1) begin
        v1_q <= in_valid_i;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: mask channels, combine source with destination and decide
  // whether the pixel copies, mixes or stays unchanged.
  // --------------------------------------------------------------------------
  pbu_pix_t    src, dst;
  pbu_pix_t    comb;
  pbu_action_e action;
  pbu_s1_t     s1_d, s1_q;

  assign action = pbu_action_e'(in_data_i.action);

  always_comb begin
    src[0] = in_data_i.src_red   & chan_mask(2'd0);
    src[1] = in_data_i.src_green & chan_mask(2'd1);
    src[2] = in_data_i.src_blue  & chan_mask(2'd2);
    dst[0] = in_data_i.dst_red   & chan_mask(2'd0);
    dst[1] = in_data_i.dst_green & chan_mask(2'd1);
    dst[2] = in_data_i.dst_blue  & chan_mask(2'd2);
  end

  // Per-channel combine: saturating add, subtract clamped at zero, or the
  // product scaled back by the channel width.
  always_comb begin
    logic [8:0]  sum;
    logic [15:0] prod;
    logic [15:0] scaled;
    logic [7:0]  mask;
    for (int c = 0; c < NUM_CHAN; c++) begin
      mask   = chan_mask(2'(c));
      sum    = {1'b0, src[c]} + {1'b0, dst[c]};
      prod   = 16'(src[c] * dst[c]);
      scaled = prod >> chan_bits(2'(c));
      case (action)
        ACT_ADD: comb[c] = (sum > {1'b0, mask}) ? mask : sum[7:0];
        ACT_SUB: comb[c] = (dst[c] > src[c]) ? (dst[c] - src[c]) : 8'd0;
        default: comb[c] = scaled[7:0] & mask;
      endcase
    end
  end

  always_comb begin
    s1_d.dst = dst;
    s1_d.opa = in_data_i.opacity;
    if (action == ACT_NORMAL) begin
      // Normal mode: copy at or above the opaque limit, mix below it.
      s1_d.fg  = src;
      s1_d.sel = (in_data_i.opacity >= opaque_limit_q) ? SEL_FG : SEL_MIX;
    end else begin
      // Other modes: hold the pixel when nearly transparent, copy the
      // combined color at full opacity, mix otherwise.
      s1_d.fg = comb;
      if (in_data_i.opacity <= transparent_limit_q) begin
        s1_d.sel = SEL_DST;
      end else if (in_data_i.opacity == FULL_OPACITY) begin
        s1_d.sel = SEL_FG;
      end else begin
        s1_d.sel = SEL_MIX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1 && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 and 3: weighted sum, divide by 255, final select.
  // --------------------------------------------------------------------------
  pbu_mix u_mix (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .round_offset_i (round_offset_q),
    .s1_i           (s1_q),
    .out_o          (out_data_o)
  );

endmodule
